/* rtl/versatile_interface_adapter_macros.svh */
// Assertion macros for the interface adapter.
// Used by the top level only.
`ifndef VERSATILE_INTERFACE_ADAPTER_MACROS_SVH
`define VERSATILE_INTERFACE_ADAPTER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define VIA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define VIA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/via_pkg.sv */
// Shared constants and types for the interface adapter.
// No dependencies.
package via_pkg;
  localparam int TimerBitsDefault = 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_EDGE  = 2'd3;

  localparam logic [3:0] A_ORB  = 4'd0;
  localparam logic [3:0] A_ORA  = 4'd1;
  localparam logic [3:0] A_DDRB = 4'd2;
  localparam logic [3:0] A_DDRA = 4'd3;
  localparam logic [3:0] A_T1CL = 4'd4;
  localparam logic [3:0] A_T1CH = 4'd5;
  localparam logic [3:0] A_T1LL = 4'd6;
  localparam logic [3:0] A_T1LH = 4'd7;
  localparam logic [3:0] A_T2CL = 4'd8;
  localparam logic [3:0] A_T2CH = 4'd9;
  localparam logic [3:0] A_SR   = 4'd10;
  localparam logic [3:0] A_ACR  = 4'd11;
  localparam logic [3:0] A_PCR  = 4'd12;
  localparam logic [3:0] A_IFR  = 4'd13;
  localparam logic [3:0] A_IER  = 4'd14;
  localparam logic [3:0] A_ORAN = 4'd15;

  localparam logic [1:0] L_CA1 = 2'd0;
  localparam logic [1:0] L_CA2 = 2'd1;
  localparam logic [1:0] L_CB1 = 2'd2;
  localparam logic [1:0] L_CB2 = 2'd3;

  localparam logic [6:0] F_CA2 = 7'h01;
  localparam logic [6:0] F_CA1 = 7'h02;
  localparam logic [6:0] F_CB2 = 7'h08;
  localparam logic [6:0] F_CB1 = 7'h10;
  localparam logic [6:0] F_T2  = 7'h20;
  localparam logic [6:0] F_T1  = 7'h40;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] port_a_pins;
    logic [7:0] port_b_pins;
    logic [1:0] line_select;
    logic       edge_rising;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
    logic [7:0] port_a_out;
    logic [7:0] port_b_out;
  } result_t;
endpackage

/* rtl/versatile_interface_adapter.sv */
// Top level: adapter core and output register with result skid stage.
// Depends on via_pkg, via_core and versatile_interface_adapter_macros.svh.
// A result goes to the output register, or to the skid slot when the output stalls.
// Throughput: one item per cycle while in_ready is high; the core state update is a single pass.
// A skid buffer keeps in_ready high while one result waits downstream.
// Reset (rst, synchronous) clears ports, flags, enables, timers; timer bytes 0xff.
`include "versatile_interface_adapter_macros.svh"
module versatile_interface_adapter import via_pkg::*; #(
  parameter int TIMER_BITS = TimerBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [3:0] reg_addr,
  input  logic [7:0] write_data,
  input  logic [7:0] port_a_pins,
  input  logic [7:0] port_b_pins,
  input  logic [1:0] line_select,
  input  logic       edge_rising,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       irq_out,
  output logic [7:0] port_a_out,
  output logic [7:0] port_b_out
);
  item_t   item;
  result_t res, main_q, skid_q;
  logic    step, main_v, skid_v;

  // Accept whenever the skid slot is free; state advances at the transfer.
  assign in_ready = !skid_v;
  assign step = in_valid && in_ready;
  assign item = '{opcode, reg_addr, write_data, port_a_pins, port_b_pins,
                  line_select, edge_rising};

  via_core #(.TIMER_BITS(TIMER_BITS)) u_core (
    .clk(clk), .rst(rst), .step(step), .item(item), .res(res)
  );

  // Output register with skid: hold a result in skid when output stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0; skid_v <= 1'b0;
    end else begin
      if (!main_v || out_ready) begin
        if (skid_v) begin
          main_v <= 1'b1; skid_v <= 1'b0;
        end else begin
          main_v <= step;
        end
      end else if (step) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v || out_ready) begin
      main_q <= skid_v ? skid_q : res;
    end
    if (main_v && !out_ready && step) begin
      skid_q <= res;
    end
  end

  assign out_valid  = main_v;
  assign read_data  = main_q.read_data;
  assign irq_out    = main_q.irq_out;
  assign port_a_out = main_q.port_a_out;
  assign port_b_out = main_q.port_b_out;

  `VIA_ASSERT_IMP(a_skid_needs_main, skid_v, main_v)
  `VIA_ASSERT_NEXT(a_accept_gives_result, step, out_valid)
  `VIA_ASSERT_NEXT(a_stall_fills_skid, main_v && !out_ready && step, skid_v)
endmodule

/* rtl/via_core.sv */
// Register file, flags and timers; one item updates state and forms a result.
// Depends on via_pkg.
module via_core import via_pkg::*; #(
  parameter int TIMER_BITS = TimerBitsDefault
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  output result_t res
);
  localparam int TW = TIMER_BITS;

  logic [7:0] orb, ora, ddrb, ddra, t1ll, t1lh, t2ll, sr, acr, pcr;
  logic [6:0] flags, enables;
  logic [15:0] latch;
  logic [TW-1:0] t1, t2;
  logic arm1, arm2, reload;

  logic [7:0] orb_next, ora_next, ddrb_next, ddra_next, t1ll_next, t1lh_next;
  logic [7:0] t2ll_next, sr_next, acr_next, pcr_next;
  logic [6:0] flags_next, enables_next;
  logic [15:0] latch_next;
  logic [TW-1:0] t1_next, t2_next;
  logic arm1_next, arm2_next, reload_next;
  logic [7:0] rd;
  logic [31:0] t1w, t2w;
  logic [6:0] clr_a, clr_b;
  logic pol_ok;

  assign t1w = 32'(t1);
  assign t2w = 32'(t2);
  assign clr_a = ((pcr & 8'h0a) != 8'h02) ? (F_CA1 | F_CA2) : F_CA1;
  assign clr_b = ((pcr & 8'ha0) != 8'h20) ? (F_CB1 | F_CB2) : F_CB1;

  always_comb begin
    orb_next = orb; ora_next = ora; ddrb_next = ddrb; ddra_next = ddra;
    t1ll_next = t1ll; t1lh_next = t1lh; t2ll_next = t2ll;
    sr_next = sr; acr_next = acr; pcr_next = pcr;
    flags_next = flags; enables_next = enables; latch_next = latch;
    t1_next = t1; t2_next = t2; arm1_next = arm1; arm2_next = arm2;
    reload_next = reload; rd = 8'h00; pol_ok = 1'b0;
    case (item.opcode)
      OP_TICK: begin
        if (reload) begin
          t1_next = TW'({16'h0, latch}); reload_next = 1'b0;
        end else if (t1 == '0) begin
          t1_next = '1; reload_next = 1'b1;
          if (arm1) begin
            flags_next = flags_next | F_T1;
            if (!acr[6]) arm1_next = 1'b0;
          end
        end else begin
          t1_next = t1 - 1'b1;
        end
        if (t2 == '0 && arm2) begin
          flags_next = flags_next | F_T2; arm2_next = 1'b0;
        end
        t2_next = t2 - 1'b1;
      end
      OP_READ: begin
        case (item.reg_addr)
          A_ORB: begin
            flags_next = flags & ~clr_b;
            if (acr[7]) latch_next = {t1lh, t1ll};
            rd = (item.port_b_pins & ~ddrb) | (orb & ddrb);
          end
          A_ORA: begin
            flags_next = flags & ~clr_a; rd = item.port_a_pins;
          end
          A_ORAN: rd = item.port_a_pins;
          A_T1CL: begin
            flags_next = flags & ~F_T1; rd = t1w[7:0];
          end
          A_T1CH: rd = t1w[15:8];
          A_T2CL: begin
            flags_next = flags & ~F_T2; rd = t2w[7:0];
          end
          A_T2CH: rd = t2w[15:8];
          A_IFR:  rd = {|(flags & enables), flags};
          A_IER:  rd = {1'b1, enables};
          A_DDRB: rd = ddrb;
          A_DDRA: rd = ddra;
          A_T1LL: rd = t1ll;
          A_T1LH: rd = t1lh;
          A_SR:   rd = sr;
          A_ACR:  rd = acr;
          A_PCR:  rd = pcr;
          default: rd = 8'h00;
        endcase
      end
      OP_WRITE: begin
        case (item.reg_addr)
          A_ORB: begin
            flags_next = flags & ~clr_b; orb_next = item.write_data;
          end
          A_ORA: begin
            flags_next = flags & ~clr_a; ora_next = item.write_data;
          end
          A_ORAN: ora_next = item.write_data;
          A_DDRB: ddrb_next = item.write_data;
          A_DDRA: ddra_next = item.write_data;
          A_T1CL, A_T1LL: begin
            t1ll_next = item.write_data; latch_next = {t1lh, item.write_data};
          end
          A_T1CH: begin
            t1lh_next = item.write_data; latch_next = {item.write_data, t1ll};
            t1_next = TW'({16'h0, item.write_data, t1ll});
            arm1_next = 1'b1; reload_next = 1'b0; flags_next = flags & ~F_T1;
          end
          A_T1LH: begin
            t1lh_next = item.write_data; latch_next = {item.write_data, t1ll};
            flags_next = flags & ~F_T1;
          end
          A_T2CL: t2ll_next = item.write_data;
          A_T2CH: begin
            t2_next = TW'({16'h0, item.write_data, t2ll});
            arm2_next = 1'b1; flags_next = flags & ~F_T2;
          end
          A_SR:  sr_next = item.write_data;
          A_ACR: begin
            latch_next = {t1lh, t1ll}; acr_next = item.write_data;
          end
          A_PCR: pcr_next = item.write_data;
          A_IFR: flags_next = flags & ~item.write_data[6:0];
          A_IER: begin
            if (item.write_data[7]) enables_next = enables | item.write_data[6:0];
            else enables_next = enables & ~item.write_data[6:0];
          end
          default: ;
        endcase
      end
      default: begin
        case (item.line_select)
          L_CA1: if (pcr[0] == item.edge_rising) flags_next = flags | F_CA1;
          L_CA2: begin
            pol_ok = !pcr[3] && (pcr[2] == item.edge_rising);
            if (pol_ok) flags_next = flags | F_CA2;
          end
          L_CB1: if (pcr[4] == item.edge_rising) flags_next = flags | F_CB1;
          default: begin
            pol_ok = !pcr[7] && (pcr[6] == item.edge_rising);
            if (pol_ok) flags_next = flags | F_CB2;
          end
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      orb <= '0; ora <= '0; ddrb <= '0; ddra <= '0;
      t1ll <= 8'hff; t1lh <= 8'hff; t2ll <= 8'hff;
      sr <= '0; acr <= '0; pcr <= '0;
      flags <= '0; enables <= '0; latch <= '0;
      t1 <= '0; t2 <= '0; arm1 <= 1'b0; arm2 <= 1'b0; reload <= 1'b0;
    end else if (step) begin
      orb <= orb_next; ora <= ora_next; ddrb <= ddrb_next; ddra <= ddra_next;
      t1ll <= t1ll_next; t1lh <= t1lh_next; t2ll <= t2ll_next;
      sr <= sr_next; acr <= acr_next; pcr <= pcr_next;
      flags <= flags_next; enables <= enables_next; latch <= latch_next;
      t1 <= t1_next; t2 <= t2_next; arm1 <= arm1_next; arm2 <= arm2_next;
      reload <= reload_next;
    end
  end

  assign res.read_data  = rd;
  assign res.irq_out    = |(flags_next & enables_next);
  assign res.port_a_out = ora_next | ~ddra_next;
  assign res.port_b_out = orb_next | ~ddrb_next;
endmodule
